// ===== sv/text_console_writer_core_macros.svh =====
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define TCW_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw assertion failed");

// consequent must hold in the cycle after the antecedent
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`else

`define TCW_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/tcw_pkg.sv =====
package tcw_pkg;

  // field widths
  localparam int MODE_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;
  localparam int CELL_W      = CHAR_W + ATTR_W;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  // item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_MOVE  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BG_COLOR = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BG_BLINK = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;

  // reset values of the colour registers
  localparam logic [3:0] RESET_FG    = 4'd7;
  localparam logic [2:0] RESET_BG    = 3'd0;
  localparam logic       RESET_BLINK = 1'b0;

  // attribute byte: foreground in the low nibble, background and blink above
  function automatic logic [ATTR_W-1:0] make_attr(input logic [3:0] fg,
                                                  input logic [2:0] bg,
                                                  input logic       blink);
    return {blink, bg, fg};
  endfunction

endpackage

// ===== sv/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/text_console_writer_core.sv =====
// text console writer: cell store in one single-port-write ram plus a cursor
// put, move and clear strobe done in the cycle after start; a read goes through S_READ first
// a scroll keeps busy high while a sweep blanks the new bottom row
// clear keeps busy high while the whole store is blanked, one ram write per cycle
// after reset busy stays high while the store is blanked
// results are strobed on done for one cycle; the receiver cannot stall
`include "text_console_writer_core_macros.svh"

module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [MODE_W-1:0]      mode,
  input  logic [CHAR_W-1:0]      char_code,
  input  logic [COL_W-1:0]       col,
  input  logic [ROW_W-1:0]       row,
  output logic                   done,
  output logic [COL_W-1:0]       cursor_col,
  output logic [ROW_W-1:0]       cursor_row,
  output logic [CHAR_W-1:0]      cell_char,
  output logic [ATTR_W-1:0]      cell_attr,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SWEEP
  } state_t;

  state_t              state;
  logic [CW-1:0]       cur_c;
  logic [RW-1:0]       cur_r;
  logic [RW-1:0]       top;
  logic [AW-1:0]       sweep;
  logic [AW-1:0]       sweep_base;
  logic [AW-1:0]       sweep_end;
  logic [ATTR_W-1:0]   fill_attr;
  logic [3:0]          fg_color;
  logic [2:0]          bg_color;
  logic                bg_blink;
  logic [CHAR_W-1:0]   rd_char;
  logic [ATTR_W-1:0]   rd_attr;

  logic                accept;
  mode_t               item_mode;
  logic [CW-1:0]       col_sat;
  logic [RW-1:0]       row_sat;
  logic [CW-1:0]       sel_c;
  logic [RW-1:0]       sel_r;
  logic [RW:0]         phys_sum;
  logic [RW-1:0]       phys_r;
  logic [AW-1:0]       cell_addr;
  logic [AW-1:0]       top_base;
  logic [RW-1:0]       top_inc;
  logic [ATTR_W-1:0]   cur_attr;
  logic                is_newline;
  logic                is_backspace;
  logic                at_end;
  logic                at_bottom;
  logic                put_char;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [CELL_W-1:0]   ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= RESET_FG;
      bg_color <= RESET_BG;
      bg_blink <= RESET_BLINK;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FG_COLOR: fg_color <= cfg_data[3:0];
        CFG_BG_COLOR: bg_color <= cfg_data[2:0];
        CFG_BG_BLINK: bg_blink <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // item decode and address of the addressed cell
  always_comb begin
    accept       = start && (state == S_IDLE);
    item_mode    = mode_t'(mode);
    col_sat      = (int'(col) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(col);
    row_sat      = (int'(row) >= ROWS) ? RW'(ROWS - 1) : RW'(row);
    sel_c        = (item_mode == MODE_READ) ? col_sat : cur_c;
    sel_r        = (item_mode == MODE_READ) ? row_sat : cur_r;
    // rows are stored as a ring starting at top
    phys_sum     = {1'b0, sel_r} + {1'b0, top};
    phys_r       = (int'(phys_sum) >= ROWS) ? RW'(phys_sum - (RW+1)'(ROWS))
                                            : RW'(phys_sum);
    cell_addr    = AW'(phys_r) * AW'(COLUMNS) + AW'(sel_c);
    top_base     = AW'(top) * AW'(COLUMNS);
    top_inc      = (int'(top) == ROWS - 1) ? '0 : top + 1'b1;
    cur_attr     = make_attr(fg_color, bg_color, bg_blink);
    is_newline   = (char_code == CHAR_NEWLINE);
    is_backspace = (char_code == CHAR_BACKSPACE);
    at_end       = (int'(cur_c) == COLUMNS - 1);
    at_bottom    = (int'(cur_r) == ROWS - 1);
    put_char     = accept && (item_mode == MODE_PUT) && !is_newline && !is_backspace;
  end

  // ram write: blanking sweep, else a stored character
  always_comb begin
    if (state == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_base + sweep;
      ram_wdata = {fill_attr, CHAR_SPACE};
    end else begin
      ram_we    = put_char;
      ram_waddr = cell_addr;
      ram_wdata = {cur_attr, char_code};
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  // control state machine and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      cur_c      <= '0;
      cur_r      <= '0;
      top        <= '0;
      sweep      <= '0;
      sweep_base <= '0;
      sweep_end  <= AW'(CELLS - 1);
      fill_attr  <= make_attr(RESET_FG, RESET_BG, RESET_BLINK);
      done       <= 1'b0;
      rd_char    <= '0;
      rd_attr    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            done    <= 1'b1;
            rd_char <= '0;
            rd_attr <= '0;
            unique case (item_mode)
              MODE_PUT: begin
                if (is_newline || (put_char && at_end)) begin
                  cur_c <= '0;
                  if (at_bottom) begin
                    // scroll: drop the top row and blank it as the new bottom
                    top        <= top_inc;
                    sweep      <= '0;
                    sweep_base <= top_base;
                    sweep_end  <= AW'(COLUMNS - 1);
                    fill_attr  <= cur_attr;
                    state      <= S_SWEEP;
                  end else begin
                    cur_r <= cur_r + 1'b1;
                  end
                end else if (is_backspace) begin
                  if (cur_c != '0) begin
                    cur_c <= cur_c - 1'b1;
                  end
                end else begin
                  cur_c <= cur_c + 1'b1;
                end
              end
              MODE_MOVE: begin
                cur_c <= col_sat;
                cur_r <= row_sat;
              end
              MODE_CLEAR: begin
                cur_c      <= '0;
                cur_r      <= '0;
                top        <= '0;
                sweep      <= '0;
                sweep_base <= '0;
                sweep_end  <= AW'(CELLS - 1);
                fill_attr  <= cur_attr;
                state      <= S_SWEEP;
              end
              MODE_READ: begin
                done  <= 1'b0;
                state <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          done    <= 1'b1;
          rd_char <= ram_rdata[CHAR_W-1:0];
          rd_attr <= ram_rdata[CELL_W-1:CHAR_W];
          state   <= S_IDLE;
        end
        S_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == sweep_end) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // outputs
  assign busy       = (state != S_IDLE);
  assign cursor_col = COL_W'(cur_c);
  assign cursor_row = ROW_W'(cur_r);
  assign cell_char  = rd_char;
  assign cell_attr  = rd_attr;

  // checks
  `TCW_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, done || (state == S_READ))
  `TCW_ASSERT_NEXT(a_read_one_cycle, clk, rst, state == S_READ, done && (state == S_IDLE))
  `TCW_ASSERT_NEXT(a_sweep_ends, clk, rst, (state == S_SWEEP) && (sweep == sweep_end),
                   state == S_IDLE)
  `TCW_ASSERT_SAME(a_ring_in_range, clk, rst, 1'b1,
                   (int'(top) < ROWS) && (int'(cur_r) < ROWS) && (int'(cur_c) < COLUMNS))
  `TCW_ASSERT_SAME(a_no_write_on_read, clk, rst, state == S_READ, !ram_we)

endmodule

// ===== bench/tb_text_console_writer_core.sv =====
`timescale 1ns / 1ps

module tb_text_console_writer_core;
  import tcw_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int QUIET_MAX  = 20000;
  localparam int PHASES     = 8;
  localparam int PHASE_CMDS = 119;
  localparam int ERR_SHOWN  = 200;

  // index past the end of the register list, the block ignores it
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    mode_t             mode;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  ccol;
    logic [ROW_W-1:0]  crow;
    logic [CHAR_W-1:0] rd_char;
    logic [ATTR_W-1:0] rd_attr;
  } console_view_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [MODE_W-1:0]      mode;
  logic [CHAR_W-1:0]      char_code;
  logic [COL_W-1:0]       col;
  logic [ROW_W-1:0]       row;
  logic                   done;
  logic [COL_W-1:0]       cursor_col;
  logic [ROW_W-1:0]       cursor_row;
  logic [CHAR_W-1:0]      cell_char;
  logic [ATTR_W-1:0]      cell_attr;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  text_console_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .char_code (char_code),
    .col       (col),
    .row       (row),
    .done      (done),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .cell_char (cell_char),
    .cell_attr (cell_attr),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // screen copy, cursor and colours as the block should hold them
  logic [CELL_W-1:0] screen [CELLS];
  int                cur_x;
  int                cur_y;
  logic [3:0]        colour_fg;
  logic [2:0]        colour_bg;
  logic              colour_blink;

  console_cmd_t  cmds_pending [$];
  console_view_t views_due [$];
  console_cmd_t  cmd_on_bus;
  int            sender_idle_pct;
  int            errors;
  int            quiet;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {colour_blink, colour_bg, colour_fg, CHAR_SPACE};
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
  endfunction

  // cursor to the next line, scrolling up one row past the bottom
  function automatic void line_feed();
    cur_x = 0;
    cur_y++;
    if (cur_y >= ROWS) begin
      cur_y = ROWS - 1;
      for (int i = 0; i < COLUMNS * (ROWS - 1); i++) screen[i] = screen[i + COLUMNS];
      for (int i = COLUMNS * (ROWS - 1); i < CELLS; i++) screen[i] = blank_cell();
    end
  endfunction

  function automatic int sat(input int v, input int lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  // apply one item to the screen copy and give the view the block should report
  function automatic console_view_t console_apply(input console_cmd_t c);
    console_view_t v;
    int            idx;
    v.rd_char = '0;
    v.rd_attr = '0;
    case (c.mode)
      MODE_PUT: begin
        if (c.code == CHAR_NEWLINE) begin
          line_feed();
        end else if (c.code == CHAR_BACKSPACE) begin
          if (cur_x > 0) cur_x--;
        end else begin
          screen[cur_y * COLUMNS + cur_x] = {colour_blink, colour_bg, colour_fg, c.code};
          cur_x++;
          if (cur_x >= COLUMNS) line_feed();
        end
      end
      MODE_MOVE: begin
        cur_x = sat(int'(c.col), COLUMNS);
        cur_y = sat(int'(c.row), ROWS);
      end
      MODE_CLEAR: begin
        blank_screen();
        cur_x = 0;
        cur_y = 0;
      end
      default: begin
        idx = sat(int'(c.row), ROWS) * COLUMNS + sat(int'(c.col), COLUMNS);
        {v.rd_attr, v.rd_char} = screen[idx];
      end
    endcase
    v.ccol = cur_x[COL_W-1:0];
    v.crow = cur_y[ROW_W-1:0];
    return v;
  endfunction

  function automatic console_cmd_t mk(input mode_t m, input int code, input int x, input int y);
    console_cmd_t c;
    c.mode = m;
    c.code = code[CHAR_W-1:0];
    c.col  = x[COL_W-1:0];
    c.row  = y[ROW_W-1:0];
    return c;
  endfunction

  // mostly text with line control, cursor jumps near the bottom-right to
  // provoke wraps and scrolls, reads, and the odd clear
  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int           pick;
    pick   = $urandom_range(999);
    c.code = CHAR_W'($urandom_range(255));
    c.col  = COL_W'($urandom_range(127));
    c.row  = ROW_W'($urandom_range(31));
    if (pick < 640) begin
      c.mode = MODE_PUT;
      case ($urandom_range(9))
        0: c.code = CHAR_NEWLINE;
        1: c.code = CHAR_BACKSPACE;
        default: ;
      endcase
    end else if (pick < 985) begin
      c.mode = (pick < 780) ? MODE_MOVE : MODE_READ;
      if ($urandom_range(4) != 0) begin
        c.col = COL_W'($urandom_range(COLUMNS - 1));
        c.row = ROW_W'($urandom_range(ROWS - 1));
        if ($urandom_range(1) == 1) c.row = ROW_W'(ROWS - 1 - $urandom_range(2));
        if (c.mode == MODE_MOVE && $urandom_range(1) == 1)
          c.col = COL_W'(COLUMNS - 1 - $urandom_range(3));
      end
    end else begin
      c.mode = MODE_CLEAR;
    end
    return c;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FG_COLOR: colour_fg    = val[3:0];
      CFG_BG_COLOR: colour_bg    = val[2:0];
      CFG_BG_BLINK: colour_blink = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // every item through, every view in and the block no longer busy
  task automatic wait_idle();
    do @(negedge clk);
    while (cmds_pending.size() != 0 || start || views_due.size() != 0 || busy);
    repeat (2) @(posedge clk);
  endtask

  // driver: holds an item until accepted, then maybe idles before the next
  always @(posedge clk) begin : drive_cmds
    console_cmd_t nxt;
    logic         may_launch;
    if (rst) begin
      start <= 1'b0;
    end else begin
      may_launch = !start;
      if (start && !busy) begin
        views_due.push_back(console_apply(cmd_on_bus));
        may_launch = 1'b1;
      end
      if (may_launch) begin
        if (cmds_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = cmds_pending.pop_front();
          cmd_on_bus <= nxt;
          mode       <= nxt.mode;
          char_code  <= nxt.code;
          col        <= nxt.col;
          row        <= nxt.row;
          start      <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each strobed view with the oldest one due
  always @(posedge clk) begin : check_views
    console_view_t want;
    if (!rst && done) begin
      if (views_due.size() == 0) begin
        errors++;
        $error("view strobed with no item outstanding");
      end else begin
        want = views_due.pop_front();
        if (cursor_col !== want.ccol) begin
          errors++;
          if (errors <= ERR_SHOWN)
            $error("cursor_col: expected %0d, got %0d", want.ccol, cursor_col);
        end
        if (cursor_row !== want.crow) begin
          errors++;
          if (errors <= ERR_SHOWN)
            $error("cursor_row: expected %0d, got %0d", want.crow, cursor_row);
        end
        if (cell_char !== want.rd_char) begin
          errors++;
          if (errors <= ERR_SHOWN)
            $error("cell_char: expected %02h, got %02h", want.rd_char, cell_char);
        end
        if (cell_attr !== want.rd_attr) begin
          errors++;
          if (errors <= ERR_SHOWN)
            $error("cell_attr: expected %02h, got %02h", want.rd_attr, cell_attr);
        end
      end
    end
  end

  // watchdog on cycles with no handshake either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  int idle_table [4] = '{0, 70, 0, 21};

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    mode            = MODE_PUT;
    char_code       = '0;
    col             = '0;
    row             = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_FG_COLOR;
    cfg_data        = '0;
    cmd_on_bus      = '0;
    sender_idle_pct = 0;
    errors          = 0;
    quiet           = 0;
    colour_fg       = RESET_FG;
    colour_bg       = RESET_BG;
    colour_blink    = RESET_BLINK;
    cur_x           = 0;
    cur_y           = 0;
    blank_screen();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, extreme codes, saturation, wrap and scroll
    cmds_pending.push_back(mk(MODE_READ,  'hA5, 0, 0));
    cmds_pending.push_back(mk(MODE_PUT,   'h41, 127, 31));
    cmds_pending.push_back(mk(MODE_PUT,   'hFF, 0, 0));
    cmds_pending.push_back(mk(MODE_PUT,   'h00, 5, 5));
    cmds_pending.push_back(mk(MODE_READ,  0, 0, 0));
    cmds_pending.push_back(mk(MODE_READ,  0, 1, 0));
    cmds_pending.push_back(mk(MODE_MOVE,  'hFF, 0, 0));
    cmds_pending.push_back(mk(MODE_PUT,   int'(CHAR_BACKSPACE), 0, 0));
    cmds_pending.push_back(mk(MODE_MOVE,  0, 127, 31));
    cmds_pending.push_back(mk(MODE_PUT,   'h5A, 0, 0));
    cmds_pending.push_back(mk(MODE_READ,  0, COLUMNS - 1, ROWS - 2));
    cmds_pending.push_back(mk(MODE_READ,  0, 0, ROWS - 1));
    cmds_pending.push_back(mk(MODE_MOVE,  0, COLUMNS - 2, ROWS - 1));
    cmds_pending.push_back(mk(MODE_PUT,   'h7E, 0, 0));
    cmds_pending.push_back(mk(MODE_PUT,   int'(CHAR_NEWLINE), 64, 16));
    cmds_pending.push_back(mk(MODE_READ,  0, 127, 31));
    cmds_pending.push_back(mk(MODE_READ,  0, COLUMNS - 2, ROWS - 2));
    cmds_pending.push_back(mk(MODE_MOVE,  'h0A, 5, 3));
    cmds_pending.push_back(mk(MODE_PUT,   int'(CHAR_BACKSPACE), 0, 0));
    cmds_pending.push_back(mk(MODE_CLEAR, 'hFF, 127, 31));
    cmds_pending.push_back(mk(MODE_READ,  0, COLUMNS - 1, ROWS - 1));
    cmds_pending.push_back(mk(MODE_PUT,   int'(CHAR_NEWLINE), 0, 0));
    cmds_pending.push_back(mk(MODE_READ,  'h08, 0, 0));

    // random phases under changing colours and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: ;
        1: begin
          write_reg(CFG_FG_COLOR, 4'd0);
          write_reg(CFG_BG_COLOR, 4'd0);
          write_reg(CFG_BG_BLINK, 4'd0);
        end
        2: begin
          write_reg(CFG_FG_COLOR, 4'hF);
          write_reg(CFG_BG_COLOR, 4'hF);
          write_reg(CFG_BG_BLINK, 4'hF);
        end
        default: begin
          write_reg(CFG_FG_COLOR, CFG_DATA_W'($urandom_range(15)));
          write_reg(CFG_BG_COLOR, CFG_DATA_W'($urandom_range(15)));
          write_reg(CFG_BG_BLINK, CFG_DATA_W'($urandom_range(15)));
        end
      endcase
      if (ph % 3 == 1) write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(15)));
      sender_idle_pct = idle_table[ph % 4];
      repeat (PHASE_CMDS) cmds_pending.push_back(random_cmd());
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && views_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
